FILE: src/fuel_limited_min_refuel_path_top_assert.svh
// Assertion macros for the fewest-refuel route finder.
`ifndef FUEL_LIMITED_MIN_REFUEL_PATH_TOP_ASSERT_SVH
`define FUEL_LIMITED_MIN_REFUEL_PATH_TOP_ASSERT_SVH

// Checked outside reset.
`define RFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define RFP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/rfp_pkg.sv
// Shared types and codes of the fewest-refuel route finder.
package rfp_pkg;

  // Request types on the input stream
  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_TANK  = 1'b0;
  localparam logic CFG_NODES = 1'b1;

  // Item kinds decided by the front end
  localparam logic [1:0] KIND_EDGE   = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_MISS   = 2'd2;
  localparam logic [1:0] KIND_SAME   = 2'd3;

  localparam int FIELD_W = 8;
  localparam int COST_W  = 32;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [COST_W-1:0]  cost;
  } rfp_item_t;

  // Handshake between front end queue and back end
  typedef struct packed {
    logic valid;
    logic pop;
  } rfp_q_ctl_t;

endpackage

FILE: src/rfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rfp_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module rfp_front import rfp_pkg::*; #(
  parameter int MAX_NODES = 256,
  localparam int NCW = $clog2(MAX_NODES) + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_type,
  input  logic [FIELD_W-1:0] in_a,
  input  logic [FIELD_W-1:0] in_b,
  input  logic [COST_W-1:0]  in_cost,
  input  logic [NCW-1:0]     node_lim,
  output rfp_item_t          q_item,
  input  rfp_q_ctl_t         q_ctl_in,
  output logic               q_valid
);

  localparam int CW = (NCW > FIELD_W) ? NCW : FIELD_W;
  localparam int QD = 4;

  rfp_item_t  fifo [QD];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  rfp_item_t  cls;
  logic       push;
  logic       pop;

  always_comb begin
    cls.a    = in_a;
    cls.b    = in_b;
    cls.cost = in_cost;
    priority if (in_type == REQ_EDGE) begin
      cls.kind = KIND_EDGE;
    end else if (CW'(in_a) >= CW'(node_lim) || CW'(in_b) >= CW'(node_lim)) begin
      cls.kind = KIND_MISS;
    end else if (in_a == in_b) begin
      cls.kind = KIND_SAME;
    end else begin
      cls.kind = KIND_SEARCH;
    end
  end

  assign in_ready = (cnt != 3'(QD));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 3'd0);
  assign pop      = q_ctl_in.pop && q_valid;
  assign q_item   = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end

endmodule

FILE: src/rfp_back.sv
// Back end: edge store writes and the per-query fewest-refuel search.
module rfp_back import rfp_pkg::*; #(
  parameter int MAX_NODES        = 256,
  parameter int MAX_EDGE_ENTRIES = 8192,
  localparam int NW  = $clog2(MAX_NODES),
  localparam int NCW = NW + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  rfp_item_t         q_item,
  output rfp_q_ctl_t        q_ctl,
  input  logic [COST_W-1:0] tank,
  input  logic [NCW-1:0]    node_lim,
  output logic              o_valid,
  input  logic              o_ready,
  output logic              o_reach,
  output logic [7:0]        o_count
);

  localparam int RW     = NW + 1;
  localparam int CW     = (NCW > FIELD_W) ? NCW : FIELD_W;
  localparam int EAW    = $clog2(MAX_EDGE_ENTRIES);
  localparam int EFW    = $clog2(MAX_EDGE_ENTRIES + 1);
  localparam int EDGE_W = 2 * FIELD_W + COST_W;
  localparam int NODE_W = 1 + RW + COST_W;
  localparam logic [RW-1:0] INF = {RW{1'b1}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EW0   = 4'd1;
  localparam logic [3:0] S_EW1   = 4'd2;
  localparam logic [3:0] S_CLR   = 4'd3;
  localparam logic [3:0] S_SRC   = 4'd4;
  localparam logic [3:0] S_FIND  = 4'd5;
  localparam logic [3:0] S_ESCAN = 4'd6;
  localparam logic [3:0] S_ECHK  = 4'd7;
  localparam logic [3:0] S_RELAX = 4'd8;
  localparam logic [3:0] S_DST   = 4'd9;
  localparam logic [3:0] S_RDST  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]        state;
  rfp_item_t         cur;
  logic [EFW-1:0]    fill;
  logic [EFW-1:0]    eidx;
  logic [NCW-1:0]    scan;
  logic              pend;
  logic [NW-1:0]     pend_idx;
  logic              have;
  logic [NW-1:0]     u;
  logic [RW-1:0]     ur;
  logic [COST_W-1:0] uf;
  logic [NW-1:0]     v;
  logic [COST_W-1:0] ecost;
  logic              res_reach;
  logic [7:0]        res_count;

  // RAM ports
  logic              e_we;
  logic [EAW-1:0]    e_waddr;
  logic [EDGE_W-1:0] e_wdata;
  logic [EAW-1:0]    e_raddr;
  logic [EDGE_W-1:0] e_rdata;
  logic              n_we;
  logic [NW-1:0]     n_waddr;
  logic [NODE_W-1:0] n_wdata;
  logic [NW-1:0]     n_raddr;
  logic [NODE_W-1:0] n_rdata;

  logic [FIELD_W-1:0] ed_from;
  logic [FIELD_W-1:0] ed_to;
  logic [COST_W-1:0]  ed_cost;
  logic               nd_set;
  logic [RW-1:0]      nd_r;
  logic [COST_W-1:0]  nd_f;
  logic               take;
  logic               fit_left;
  logic               fit_full;
  logic [RW-1:0]      cand_r;
  logic [COST_W-1:0]  cand_f;
  logic               better;
  logic               room;

  assign ed_from = e_rdata[EDGE_W-1 -: FIELD_W];
  assign ed_to   = e_rdata[COST_W +: FIELD_W];
  assign ed_cost = e_rdata[COST_W-1:0];
  assign nd_set  = n_rdata[NODE_W-1];
  assign nd_r    = n_rdata[COST_W +: RW];
  assign nd_f    = n_rdata[COST_W-1:0];

  assign room = ({1'b0, fill} + (EFW+1)'(2)) <= (EFW+1)'(MAX_EDGE_ENTRIES);

  // Best unsettled node so far in the find scan
  assign take = !nd_set && (nd_r != INF) &&
                (!have || nd_r < ur || (nd_r == ur && nd_f > uf));

  // Driving on the fuel left beats refilling whenever it fits
  assign fit_left = (ecost <= uf);
  assign fit_full = (ecost <= tank);
  assign cand_r   = fit_left ? ur : ur + RW'(1);
  assign cand_f   = fit_left ? (uf - ecost) : (tank - ecost);
  assign better   = (fit_left || fit_full) &&
                    (cand_r < nd_r || (cand_r == nd_r && cand_f > nd_f));

  assign q_ctl.valid = q_valid;
  assign q_ctl.pop   = (state == S_IDLE) && q_valid;

  always_comb begin
    e_we    = 1'b0;
    e_waddr = fill[EAW-1:0];
    e_wdata = {cur.a, cur.b, cur.cost};
    e_raddr = eidx[EAW-1:0];
    n_we    = 1'b0;
    n_waddr = scan[NW-1:0];
    n_wdata = {1'b0, INF, {COST_W{1'b0}}};
    n_raddr = scan[NW-1:0];
    unique case (state)
      S_EW0: begin
        e_we = 1'b1;
      end
      S_EW1: begin
        e_we    = 1'b1;
        e_waddr = EAW'(fill + EFW'(1));
        e_wdata = {cur.b, cur.a, cur.cost};
      end
      S_CLR: begin
        n_we = 1'b1;
      end
      S_SRC: begin
        n_we    = 1'b1;
        n_waddr = NW'(cur.a);
        n_wdata = {1'b0, {RW{1'b0}}, tank};
      end
      S_FIND: begin
        if (scan == node_lim && !pend && have) begin
          n_we    = 1'b1;
          n_waddr = u;
          n_wdata = {1'b1, ur, uf};
        end
      end
      S_ECHK: begin
        n_raddr = NW'(ed_to);
      end
      S_RELAX: begin
        n_we    = better;
        n_waddr = v;
        n_wdata = {nd_set, cand_r, cand_f};
      end
      S_DST: begin
        n_raddr = NW'(cur.b);
      end
      default: begin
      end
    endcase
  end

  rfp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGE_ENTRIES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  rfp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      o_valid <= 1'b0;
      pend    <= 1'b0;
      have    <= 1'b0;
    end else begin
      // Output register: load a new result once the old one is gone
      if (state == S_OUT && (!o_valid || o_ready)) begin
        o_valid <= 1'b1;
      end else if (o_ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            unique case (q_item.kind)
              KIND_EDGE: state <= room ? S_EW0 : S_IDLE;
              KIND_MISS: begin
                res_reach <= 1'b0;
                res_count <= 8'd0;
                state     <= S_OUT;
              end
              KIND_SAME: begin
                res_reach <= 1'b1;
                res_count <= 8'd0;
                state     <= S_OUT;
              end
              default: begin
                scan  <= '0;
                state <= S_CLR;
              end
            endcase
          end
        end
        S_EW0: state <= S_EW1;
        S_EW1: begin
          fill  <= fill + EFW'(2);
          state <= S_IDLE;
        end
        S_CLR: begin
          scan <= scan + NCW'(1);
          if (scan == node_lim - NCW'(1)) state <= S_SRC;
        end
        S_SRC: begin
          scan  <= '0;
          pend  <= 1'b0;
          have  <= 1'b0;
          state <= S_FIND;
        end
        S_FIND: begin
          if (scan != node_lim) begin
            scan     <= scan + NCW'(1);
            pend     <= 1'b1;
            pend_idx <= scan[NW-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (pend && take) begin
            have <= 1'b1;
            u    <= pend_idx;
            ur   <= nd_r;
            uf   <= nd_f;
          end
          if (scan == node_lim && !pend) begin
            eidx  <= '0;
            state <= have ? S_ESCAN : S_DST;
          end
        end
        S_ESCAN: begin
          if (eidx == fill) begin
            scan  <= '0;
            have  <= 1'b0;
            pend  <= 1'b0;
            state <= S_FIND;
          end else begin
            state <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (CW'(ed_from) == CW'(u) && CW'(ed_to) < CW'(node_lim)) begin
            v     <= NW'(ed_to);
            ecost <= ed_cost;
            state <= S_RELAX;
          end else begin
            eidx  <= eidx + EFW'(1);
            state <= S_ESCAN;
          end
        end
        S_RELAX: begin
          eidx  <= eidx + EFW'(1);
          state <= S_ESCAN;
        end
        S_DST: state <= S_RDST;
        S_RDST: begin
          res_reach <= (nd_r != INF);
          res_count <= (nd_r != INF) ? 8'(nd_r) : 8'd0;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!o_valid || o_ready) begin
            o_reach <= res_reach;
            o_count <= res_count;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/fuel_limited_min_refuel_path_top.sv
// Top level of the fewest-refuel route finder.
// Edge-add transactions (tuser 0) store an undirected road as two directed
// entries in an edge RAM of MAX_EDGE_ENTRIES; an edge that does not find two
// free entries is dropped. Query transactions (tuser 1) start from node_a with
// a full tank and return one result: reachable and the fewest refuels to
// node_b. A query with either end at or beyond node_count answers 0/0; a query
// from a node to itself answers 1/0. A query runs an array-scan search: it
// clears every node entry, then for each node that it settles it runs a find
// pass over all nodes plus an edge pass over every stored entry, relaxing each
// entry that leaves that node; a last find pass that finds nothing ends the
// search. The node RAM's one read port and the one-edge-per-step scan set
// the search time.
// A four-deep queue between the input stage and the search engine keeps
// accepting transactions while a search runs, and the output register holds
// a result until it is taken.
module fuel_limited_min_refuel_path_top import rfp_pkg::*; #(
  parameter int MAX_NODES        = 256,
  parameter int MAX_EDGE_ENTRIES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // node_a[7:0], node_b[15:8], edge_cost[47:16]
  input  logic        s_tuser,   // req_type[0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // reachable[0], refuel_count[8:1], zero[15:9]
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NCW = $clog2(MAX_NODES) + 1;

  logic [COST_W-1:0] tank_capacity;
  logic [8:0]        node_count;
  logic [NCW-1:0]    node_lim;
  rfp_item_t         q_item;
  rfp_q_ctl_t        q_ctl;
  logic              q_valid;
  logic              o_reach;
  logic [7:0]        o_count;

  // Configuration is always taken: cfg_ready is tied high
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tank_capacity <= '0;
      node_count    <= 9'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TANK:  tank_capacity <= cfg_data;
        CFG_NODES: node_count    <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // Node count in use: 0 acts as 1, values above MAX_NODES saturate
  always_comb begin
    priority if (node_count == 9'd0) begin
      node_lim = NCW'(1);
    end else if (int'(node_count) > MAX_NODES) begin
      node_lim = NCW'(MAX_NODES);
    end else begin
      node_lim = NCW'(node_count);
    end
  end

  rfp_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_type  (s_tuser),
    .in_a     (s_tdata[7:0]),
    .in_b     (s_tdata[15:8]),
    .in_cost  (s_tdata[47:16]),
    .node_lim (node_lim),
    .q_item   (q_item),
    .q_ctl_in (q_ctl),
    .q_valid  (q_valid)
  );

  rfp_back #(
    .MAX_NODES        (MAX_NODES),
    .MAX_EDGE_ENTRIES (MAX_EDGE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ctl    (q_ctl),
    .tank     (tank_capacity),
    .node_lim (node_lim),
    .o_valid  (m_tvalid),
    .o_ready  (m_tready),
    .o_reach  (o_reach),
    .o_count  (o_count)
  );

  assign m_tdata = {7'd0, o_count, o_reach};

endmodule

FILE: src/rfp_checker.sv
// Port-level checks of the route finder, bound to the top level.
`include "fuel_limited_min_refuel_path_top_assert.svh"

module rfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [31:0] cfg_data
);

  // A stalled result holds its transaction
  `RFP_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")
  // Unreachable answers carry a zero count
  `RFP_ASSERT(a_unreach, m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0, "count on miss")
  // Padding bits stay clear
  `RFP_ASSERT(a_pad, m_tvalid |-> m_tdata[15:9] == 7'd0, "padding set")
  // No result right after reset
  `RFP_ASSERT_ALWAYS(a_rst, rst |=> !m_tvalid, "result after reset")
  // Configuration never stalls
  `RFP_ASSERT(a_cfg, cfg_ready, "config stalled")

endmodule

bind fuel_limited_min_refuel_path_top rfp_checker u_rfp_checker (.*);

FILE: test/fuel_limited_min_refuel_path_checker.sv
// Checker for the fewest-refuel route finder: watches all channels, predicts and compares.
module fuel_limited_min_refuel_path_checker import rfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // node_a[7:0], node_b[15:8], edge_cost[47:16]
  input  logic        s_tuser,   // req_type[0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // reachable[0], refuel_count[8:1], zero[15:9]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int NODE_LIMIT = 256;
  localparam int ENTRY_LIMIT = 8192;
  localparam int NO_ROUTE = 511;

  typedef struct {
    logic       reach;
    logic [7:0] refuels;
  } route_answer_t;

  typedef struct {
    int          r;
    logic [31:0] f;
    int          n;
  } route_state_t;

  logic [31:0] tank_cap = '0;
  logic [8:0]  node_reg = 9'd1;
  logic [7:0]  road_from [ENTRY_LIMIT];
  logic [7:0]  road_to   [ENTRY_LIMIT];
  logic [31:0] road_cost [ENTRY_LIMIT];
  int          road_fill = 0;
  route_answer_t answer_q[$];
  int          shown = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Best-first search from src with a full tank; returns fewest refuels to dst.
  function automatic int fewest_refuels(int src, int dst, int nc);
    int           best_r [NODE_LIMIT];
    logic [31:0]  best_f [NODE_LIMIT];
    bit           done [NODE_LIMIT];
    route_state_t open_q[$];
    route_state_t cur;
    int           pick, u, v, r;
    logic [31:0]  c, f;
    bit           changed;
    for (int i = 0; i < NODE_LIMIT; i++) begin
      best_r[i] = NO_ROUTE;
      best_f[i] = '0;
      done[i] = 0;
    end
    best_r[src] = 0;
    best_f[src] = tank_cap;
    open_q.push_back('{0, tank_cap, src});
    while (open_q.size() > 0) begin
      // pop the smallest key: fewer refuels, then more fuel, then lower node
      pick = 0;
      for (int k = 1; k < open_q.size(); k++) begin
        if (open_q[k].r < open_q[pick].r ||
            (open_q[k].r == open_q[pick].r && open_q[k].f > open_q[pick].f) ||
            (open_q[k].r == open_q[pick].r && open_q[k].f == open_q[pick].f &&
             open_q[k].n < open_q[pick].n))
          pick = k;
      end
      cur = open_q[pick];
      open_q.delete(pick);
      u = cur.n;
      if (u >= nc || done[u]) continue;
      done[u] = 1;
      for (int i = 0; i < road_fill; i++) begin
        if (road_from[i] != u) continue;
        v = road_to[i];
        if (v >= nc) continue;
        c = road_cost[i];
        r = best_r[u];
        f = best_f[u];
        changed = 0;
        if (c <= f && (best_r[v] > r || (best_r[v] == r && f - c > best_f[v]))) begin
          best_r[v] = r;
          best_f[v] = f - c;
          changed = 1;
        end
        if (c <= tank_cap && (best_r[v] > r + 1 ||
            (best_r[v] == r + 1 && tank_cap - c > best_f[v]))) begin
          best_r[v] = r + 1;
          best_f[v] = tank_cap - c;
          changed = 1;
        end
        if (changed) open_q.push_back('{best_r[v], best_f[v], v});
      end
    end
    return best_r[dst];
  endfunction

  always @(posedge clk) begin
    int            nc, a, b, hops;
    route_answer_t want, got;
    if (rst) begin
      tank_cap <= '0;
      node_reg <= 9'd1;
      road_fill = 0;
      answer_q.delete();
    end else begin
      // results first: a query never answers on its own accept edge
      if (m_tvalid && m_tready) begin
        got.reach = m_tdata[0];
        got.refuels = m_tdata[8:1];
        if (answer_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (shown < 10) $display("unexpected result: reach %0d refuels %0d",
                                   got.reach, got.refuels);
          shown++;
        end else begin
          want = answer_q.pop_front();
          if (got.reach !== want.reach || got.refuels !== want.refuels) begin
            fail_count <= fail_count + 1;
            if (shown < 10)
              $display("result mismatch: expected reach %0d refuels %0d, got %0d %0d",
                       want.reach, want.refuels, got.reach, got.refuels);
            shown++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TANK) tank_cap <= cfg_data;
        else node_reg <= cfg_data[8:0];
      end
      if (s_tvalid && s_tready) begin
        a = s_tdata[7:0];
        b = s_tdata[15:8];
        if (s_tuser == REQ_EDGE) begin
          if (road_fill + 2 <= ENTRY_LIMIT) begin
            road_from[road_fill] = a;
            road_to[road_fill] = b;
            road_cost[road_fill] = s_tdata[47:16];
            road_from[road_fill+1] = b;
            road_to[road_fill+1] = a;
            road_cost[road_fill+1] = s_tdata[47:16];
            road_fill += 2;
          end
        end else begin
          nc = (node_reg == 0) ? 1 : (node_reg > NODE_LIMIT) ? NODE_LIMIT : node_reg;
          want = '{1'b0, 8'd0};
          if (a < nc && b < nc) begin
            hops = fewest_refuels(a, b, nc);
            if (hops != NO_ROUTE) want = '{1'b1, hops[7:0]};
          end
          answer_q.push_back(want);
        end
      end
    end
    pending <= answer_q.size();
  end

endmodule

FILE: test/fuel_limited_min_refuel_path_top_test.sv
// Stimulus and verdict for the fewest-refuel route finder testbench.
module fuel_limited_min_refuel_path_top_test;
  import rfp_pkg::*;

  // no-acceptance limit: longest search here settles every node with a full edge pass each
  localparam int STALL_LIMIT = 1000000;
  // quiet cycles after the last result before touching configuration
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = REQ_EDGE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_TANK;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_pct = 7;   // chance per cycle that either side holds off
  int          quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fuel_limited_min_refuel_path_top u_dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  fuel_limited_min_refuel_path_checker u_checker (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // receiver backpressure
  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= idle_pct);

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // One request transaction; tvalid stays high into the next call unless it idles.
  task automatic send_req(logic kind, logic [7:0] a, logic [7:0] b, logic [31:0] cost);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {cost, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; settle() drops it
  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stop sending, wait for every answer, then let trailing edge adds finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic on nodes below span, with some full-range noise.
  task automatic random_traffic(int count, int span, logic [31:0] cap);
    logic [7:0]  a, b;
    logic [31:0] cost;
    logic        kind;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 99) < 55) ? REQ_EDGE : REQ_QUERY;
      if ($urandom_range(0, 99) < 80) begin
        a = $urandom_range(0, span - 1);
        b = $urandom_range(0, span - 1);
        case ($urandom_range(0, 3))
          0: cost = cap;
          1: cost = cap + 1;
          default: cost = $urandom_range(0, cap);
        endcase
      end else begin
        a = $urandom;
        b = $urandom;
        cost = $urandom;
      end
      send_req(kind, a, b, cost);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one node, empty tank
    send_req(REQ_QUERY, 8'd0, 8'd0, 32'd0);     // source equals destination
    send_req(REQ_QUERY, 8'd0, 8'd1, 32'd0);     // destination beyond count
    settle();
    write_reg(CFG_NODES, 32'd0);                // zero acts as one node
    settle();
    send_req(REQ_QUERY, 8'd0, 8'd0, 32'hFFFF_FFFF);
    settle();

    // small chain: fit on fuel left, forced refuel, too costly, zero cost
    write_reg(CFG_TANK, 32'd10);
    write_reg(CFG_NODES, 32'd8);
    settle();
    send_req(REQ_EDGE, 8'd0, 8'd1, 32'd5);
    send_req(REQ_EDGE, 8'd1, 8'd2, 32'd5);
    send_req(REQ_EDGE, 8'd2, 8'd3, 32'd10);
    send_req(REQ_EDGE, 8'd3, 8'd4, 32'd11);
    send_req(REQ_EDGE, 8'd4, 8'd5, 32'd0);
    send_req(REQ_EDGE, 8'd5, 8'd6, 32'hFFFF_FFFF);
    send_req(REQ_EDGE, 8'd0, 8'd200, 32'd1);    // touches a node beyond count
    send_req(REQ_EDGE, 8'd6, 8'd6, 32'd3);
    send_req(REQ_QUERY, 8'd0, 8'd3, 32'd0);
    send_req(REQ_QUERY, 8'd3, 8'd0, 32'hFFFF_FFFF);
    send_req(REQ_QUERY, 8'd0, 8'd4, 32'd0);
    send_req(REQ_QUERY, 8'd4, 8'd5, 32'd0);
    send_req(REQ_QUERY, 8'd0, 8'd200, 32'd0);
    send_req(REQ_QUERY, 8'd255, 8'd0, 32'd0);
    send_req(REQ_QUERY, 8'd7, 8'd7, 32'd0);
    settle();

    // widest settings: count above the node limit, full 32-bit tank
    write_reg(CFG_NODES, 32'h1FF);
    write_reg(CFG_TANK, 32'hFFFF_FFFF);
    settle();
    send_req(REQ_EDGE, 8'd255, 8'd254, 32'hFFFF_FFFF);
    send_req(REQ_EDGE, 8'd254, 8'd0, 32'hFFFF_FFFF);
    send_req(REQ_QUERY, 8'd255, 8'd0, 32'd0);
    send_req(REQ_QUERY, 8'd6, 8'd5, 32'd0);
    settle();

    random_traffic(20, 8, 32'd100);
    settle();
    write_reg(CFG_NODES, 32'd256);
    settle();
    random_traffic(15, 256, 32'hFFFF_FFFF);
    settle();
    write_reg(CFG_TANK, 32'd0);
    write_reg(CFG_NODES, 32'd12);
    settle();
    idle_pct = 0;                               // stretch with no idling at all
    random_traffic(20, 12, 32'd0);
    settle();
    idle_pct = 7;
    write_reg(CFG_TANK, 32'd37);
    write_reg(CFG_NODES, 32'd5);
    settle();
    random_traffic(20, 5, 32'd37);
    settle();

    // mid-size count: a fresh road, a self query and an end beyond the count
    write_reg(CFG_NODES, 32'd16);
    write_reg(CFG_TANK, 32'd50);
    settle();
    send_req(REQ_EDGE, 8'd0, 8'd1, 32'd10);
    send_req(REQ_QUERY, 8'd0, 8'd1, 32'd0);
    send_req(REQ_QUERY, 8'd1, 8'd1, 32'd0);
    send_req(REQ_QUERY, 8'd3, 8'd20, 32'd0);
    settle();

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
